// ----- sv/tgow_pkg.sv -----
// shared types, constants and glyph tables for the text glyph oled writer
package tgow_pkg;

    localparam int PAGES = 8;

    localparam logic [7:0] CMD_COL_WINDOW  = 8'h21;
    localparam logic [7:0] CMD_PAGE_WINDOW = 8'h22;
    localparam logic [7:0] WRAP_COLUMN     = 8'd120;
    localparam logic [7:0] ADV_NARROW      = 8'd8;
    localparam logic [7:0] ADV_WIDE        = 8'd9;
    localparam logic [7:0] CASE_FOLD       = 8'd32;

    // byte slots within one character run
    localparam int          CNT_W           = 4;
    localparam logic [3:0] SLOT_COL_CMD    = 4'd0;
    localparam logic [3:0] SLOT_COL_START  = 4'd1;
    localparam logic [3:0] SLOT_COL_END    = 4'd2;
    localparam logic [3:0] SLOT_PAGE_CMD   = 4'd3;
    localparam logic [3:0] SLOT_PAGE_START = 4'd4;
    localparam logic [3:0] SLOT_PAGE_END   = 4'd5;
    localparam logic [3:0] SLOT_DATA0      = 4'd6;
    localparam logic [3:0] SLOT_LAST       = 4'd13;

    localparam logic [5:0] GLYPH_DIGIT0 = 6'd26;
    localparam logic [5:0] GLYPH_DOT    = 6'd36;
    localparam logic [5:0] GLYPH_COLON  = 6'd37;
    localparam logic [5:0] GLYPH_MINUS  = 6'd38;
    localparam logic [5:0] GLYPH_PLUS   = 6'd39;
    localparam logic [5:0] GLYPH_BLANK  = 6'd40;

    typedef enum logic [1:0] {
        ACT_PRINT      = 2'd0,
        ACT_NEW_LINE   = 2'd1,
        ACT_SET_CURSOR = 2'd2
    } t_action;

    typedef struct packed {
        logic [6:0] col;
        logic [2:0] page;
    } t_cursor;

    localparam int CUR_W     = $bits(t_cursor);
    localparam int CUR_DEPTH = 2;

    typedef struct packed {
        logic [6:0]  col;
        logic [2:0]  page;
        logic [63:0] glyph;
    } t_job;

    function automatic logic [5:0] glyph_index(input logic [7:0] code);
        logic [7:0] c;
        c = code;
        if (c >= 8'h61 && c <= 8'h7A) c = c - CASE_FOLD;
        if (c >= 8'h41 && c <= 8'h5A) return 6'(c - 8'h41);
        if (c >= 8'h30 && c <= 8'h39) return GLYPH_DIGIT0 + 6'(c - 8'h30);
        if (c == 8'h2E) return GLYPH_DOT;
        if (c == 8'h3A) return GLYPH_COLON;
        if (c == 8'h2D) return GLYPH_MINUS;
        if (c == 8'h2B) return GLYPH_PLUS;
        return GLYPH_BLANK;
    endfunction

    // first column byte in the top bits
    function automatic logic [63:0] glyph_row(input logic [5:0] idx);
        logic [63:0] r;
        case (idx)
            6'd0:    r = 64'hFC22212121_22FC00;
            6'd1:    r = 64'hFF8989898989_7600;
            6'd2:    r = 64'h7E8181818181_4200;
            6'd3:    r = 64'hFF8181818142_3C00;
            6'd4:    r = 64'hFF8989898181_8100;
            6'd5:    r = 64'hFF0909090101_0100;
            6'd6:    r = 64'h7E8181919191_5E00;
            6'd7:    r = 64'hFF1010101010_FF00;
            6'd8:    r = 64'h8181FFFF8181_0000;
            6'd9:    r = 64'h608081817F01_0100;
            6'd10:   r = 64'hFF1028448281_0000;
            6'd11:   r = 64'hFF8080808080_8000;
            6'd12:   r = 64'hFF020C02FF00_0000;
            6'd13:   r = 64'hFF06083040FF_0000;
            6'd14:   r = 64'h7E8181818181_7E00;
            6'd15:   r = 64'hFF111111110E_0000;
            6'd16:   r = 64'h7E8181A141BE_4000;
            6'd17:   r = 64'hFF111131518E_0000;
            6'd18:   r = 64'h468989898989_7200;
            6'd19:   r = 64'h0101FFFF0101_0000;
            6'd20:   r = 64'h7F8080808080_7F00;
            6'd21:   r = 64'h1F608040300F_0000;
            6'd22:   r = 64'h7F8070807F00_0000;
            6'd23:   r = 64'hC324181824C3_0000;
            6'd24:   r = 64'h0708F0F00807_0000;
            6'd25:   r = 64'h81C1A1918985_8300;
            6'd26:   r = 64'h7E8181818181_7E00;
            6'd27:   r = 64'h008084FFFF80_8000;
            6'd28:   r = 64'h82C3A1918987_C200;
            6'd29:   r = 64'h42819191_91FF_6E00;
            6'd30:   r = 64'h18141211FFFF_1000;
            6'd31:   r = 64'h4F8989898989_F100;
            6'd32:   r = 64'h7F8989898989_7100;
            6'd33:   r = 64'h010101018171_0F00;
            6'd34:   r = 64'h768989898989_7600;
            6'd35:   r = 64'h4E8989898989_7F00;
            6'd36:   r = 64'h000080800000_0000;
            6'd37:   r = 64'h000024240000_0000;
            6'd38:   r = 64'h001818181818_1800;
            6'd39:   r = 64'h0018187E7E18_1800;
            default: r = 64'h0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/tgow_ram.sv -----
// generic single-port-write ram with registered read
module tgow_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/tgow_seq.sv -----
// byte sequencer: plays out the fourteen bytes of one character run
module tgow_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  tgow_pkg::t_job       i_job,
    input  logic                 i_out_stall,
    output logic                 o_free,
    output logic                 o_out_valid,
    output logic                 o_is_data,
    output logic [7:0]           o_byte_value,
    output logic                 o_last_of_run
);

    logic                        r_busy;
    logic                        n_busy;
    logic [tgow_pkg::CNT_W-1:0]  r_cnt;
    logic [tgow_pkg::CNT_W-1:0]  n_cnt;
    tgow_pkg::t_job              r_job;
    logic                        last_beat;
    logic [tgow_pkg::CNT_W-1:0]  data_idx;
    logic [2:0]                  sel;

    assign last_beat = r_busy && !i_out_stall && (r_cnt == tgow_pkg::SLOT_LAST);
    assign o_free    = !r_busy || last_beat;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (i_load) begin
            n_busy = 1'b1;
            n_cnt  = tgow_pkg::SLOT_COL_CMD;
        end else if (last_beat) begin
            n_busy = 1'b0;
        end else if (r_busy && !i_out_stall) begin
            n_cnt = r_cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= tgow_pkg::SLOT_COL_CMD;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
    end

    assign data_idx = r_cnt - tgow_pkg::SLOT_DATA0;
    assign sel      = 3'd7 - data_idx[2:0];

    always_comb begin
        o_is_data    = 1'b0;
        o_byte_value = 8'h00;
        unique case (r_cnt)
            tgow_pkg::SLOT_COL_CMD:    o_byte_value = tgow_pkg::CMD_COL_WINDOW;
            tgow_pkg::SLOT_COL_START:  o_byte_value = {1'b0, r_job.col};
            tgow_pkg::SLOT_COL_END:    o_byte_value = {1'b0, r_job.col} + 8'd7;
            tgow_pkg::SLOT_PAGE_CMD:   o_byte_value = tgow_pkg::CMD_PAGE_WINDOW;
            tgow_pkg::SLOT_PAGE_START: o_byte_value = {5'b0, r_job.page};
            tgow_pkg::SLOT_PAGE_END:   o_byte_value = {5'b0, r_job.page};
            default: begin
                o_is_data    = 1'b1;
                o_byte_value = r_job.glyph[{sel, 3'b000} +: 8];
            end
        endcase
    end

    assign o_out_valid   = r_busy;
    assign o_last_of_run = (r_cnt == tgow_pkg::SLOT_LAST);

endmodule

// ----- sv/text_glyph_oled_writer.sv -----
// top level: text events in, page-addressed oled command and data bytes out
//
// Each print-character beat yields a run of fourteen output beats, one per cycle while the
// output is not stalled: six window command bytes then eight glyph column bytes, the last
// flagged. New-line and set-cursor beats yield nothing and never wait for the sequencer. The
// cursor lives in a small synchronous memory; every input beat passes through the
// read-modify-write stage, with the value written in the previous cycle forwarded, so a
// print beat waits there only while the byte sequencer is still playing out the prior
// run. Sustained rate for text is therefore set by the one-byte-per-cycle output. After
// reset the cursor memory is cleared, and no input beat is accepted while it is cleared.
// Spacing may be changed only while idle.
module text_glyph_oled_writer #(
    parameter int PAGES = tgow_pkg::PAGES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_char_code,
    input  logic [6:0] i_new_col,
    input  logic [2:0] i_new_page,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_is_data,
    output logic [7:0] o_byte_value,
    output logic       o_last_of_run
);

    localparam int AW = $clog2(tgow_pkg::CUR_DEPTH);
    localparam logic [AW-1:0] CUR_ADDR = '0;

    logic                   r_wide;
    logic                   r_clr;
    logic                   r_s1_vld;
    tgow_pkg::t_action      r_s1_action;
    logic [5:0]             r_s1_glyph;
    logic [6:0]             r_s1_new_col;
    logic [2:0]             r_s1_new_page;
    logic                   r_fwd_vld;
    tgow_pkg::t_cursor      r_fwd;

    logic                   in_acc;
    logic                   s1_fire;
    logic                   seq_free;
    logic                   seq_load;
    logic                   wr_en;
    tgow_pkg::t_cursor      wr_data;
    logic [tgow_pkg::CUR_W-1:0] rd_data;
    tgow_pkg::t_cursor      cur;
    tgow_pkg::t_cursor      n_cur;
    logic [2:0]             pg_inc;
    logic [2:0]             nl_page;
    logic [7:0]             col_sum;
    tgow_pkg::t_job         job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= 1'b0;
        end else if (i_cfg_we) begin
            r_wide <= i_cfg_wdata;
        end
    end

    // input stage
    assign s1_fire    = r_s1_vld && ((r_s1_action != tgow_pkg::ACT_PRINT) || seq_free);
    assign o_in_stall = r_clr || (r_s1_vld && !s1_fire);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_clr     <= 1'b1;
            r_fwd_vld <= 1'b0;
        end else begin
            r_clr     <= 1'b0;
            r_fwd_vld <= wr_en;
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_action   <= tgow_pkg::t_action'(i_action);
            r_s1_glyph    <= tgow_pkg::glyph_index(i_char_code);
            r_s1_new_col  <= i_new_col;
            r_s1_new_page <= i_new_page;
        end
        if (wr_en) begin
            r_fwd <= wr_data;
        end
    end

    // cursor memory, read every cycle, last write forwarded
    tgow_ram #(
        .WIDTH (tgow_pkg::CUR_W),
        .DEPTH (tgow_pkg::CUR_DEPTH)
    ) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (CUR_ADDR),
        .i_wdata (wr_data),
        .i_raddr (CUR_ADDR),
        .o_rdata (rd_data)
    );

    assign cur = r_fwd_vld ? r_fwd : tgow_pkg::t_cursor'(rd_data);

    assign pg_inc  = cur.page + 3'd1;
    assign nl_page = ({1'b0, pg_inc} > 4'(PAGES - 1)) ? 3'd0 : pg_inc;
    assign col_sum = {1'b0, cur.col} + (r_wide ? tgow_pkg::ADV_WIDE : tgow_pkg::ADV_NARROW);

    always_comb begin
        n_cur = cur;
        unique case (r_s1_action)
            tgow_pkg::ACT_PRINT: begin
                if (col_sum >= tgow_pkg::WRAP_COLUMN) begin
                    n_cur.col  = 7'd0;
                    n_cur.page = nl_page;
                end else begin
                    n_cur.col = col_sum[6:0];
                end
            end
            tgow_pkg::ACT_NEW_LINE: begin
                n_cur.col  = 7'd0;
                n_cur.page = nl_page;
            end
            tgow_pkg::ACT_SET_CURSOR: begin
                n_cur.col  = r_s1_new_col;
                n_cur.page = r_s1_new_page;
            end
            default: n_cur = cur;
        endcase
    end

    assign wr_en   = r_clr || s1_fire;
    assign wr_data = r_clr ? tgow_pkg::t_cursor'('0) : n_cur;

    assign seq_load  = s1_fire && (r_s1_action == tgow_pkg::ACT_PRINT);
    assign job.col   = cur.col;
    assign job.page  = cur.page;
    assign job.glyph = tgow_pkg::glyph_row(r_s1_glyph);

    tgow_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (seq_load),
        .i_job         (job),
        .i_out_stall   (i_out_stall),
        .o_free        (seq_free),
        .o_out_valid   (o_out_valid),
        .o_is_data     (o_is_data),
        .o_byte_value  (o_byte_value),
        .o_last_of_run (o_last_of_run)
    );

endmodule
